// ----- hdl/tcb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the text console character buffer.
package tcb_pkg;

    // Default geometry of the console.
    localparam int COLUMNS_DEF  = 21;
    localparam int ROWS_DEF     = 7;
    localparam int TAB_SIZE_DEF = 4;

    // Payload widths fixed by the interface.
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;
    localparam int OP_W     = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Configuration register reset value and index.
    localparam logic [CHAR_W-1:0] BELL_RESET = 8'd20;
    localparam logic              REG_BELL   = 1'b0;

    // Item operation codes.
    localparam logic [OP_W-1:0] OP_RECV = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Control characters and stored character values.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 8'h80;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_RESP
    } tcb_state_t;

endpackage

// ----- hdl/text_console_char_buffer.sv -----
`timescale 1ns / 1ps
// Top level of the text console character buffer.
//
//  Channel  Direction  Handshake        Payload
//  s_       in         s_valid/s_ready  s_op, s_char_in, s_cell_index
//  m_       out        m_valid/m_ready  m_cell_char, m_cell_filled, m_cursor_at,
//                                       m_filled_count, m_view_start, m_bell_on
//  APB      in         psel/penable     paddr, pwdata, prdata (bell_duration)
//
// One item is worked at a time: after acceptance it passes the execute state, then the
// fill state while blank cells are written, one per cycle (up to COLUMNS for a line
// step), since the cell memory takes one write per cycle, then the response state
// that loads the result. A result waiting in the output register stalls that load,
// and no new item is accepted until it is loaded. Reset clears the pointers and the
// bell; the cell memory is not cleared, so no clearing pass follows reset.
module text_console_char_buffer #(
    parameter int COLUMNS  = tcb_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcb_pkg::ROWS_DEF,
    parameter int TAB_SIZE = tcb_pkg::TAB_SIZE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tcb_pkg::OP_W-1:0]    s_op,
    input  logic [tcb_pkg::CHAR_W-1:0]  s_char_in,
    input  logic [tcb_pkg::POS_W-1:0]   s_cell_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tcb_pkg::CHAR_W-1:0]  m_cell_char,
    output logic                        m_cell_filled,
    output logic [tcb_pkg::POS_W-1:0]   m_cursor_at,
    output logic [tcb_pkg::POS_W-1:0]   m_filled_count,
    output logic [tcb_pkg::POS_W-1:0]   m_view_start,
    output logic                        m_bell_on,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcb_pkg::APB_AW-1:0]  paddr,
    input  logic [tcb_pkg::APB_DW-1:0]  pwdata,
    output logic [tcb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tcb_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [CHAR_W-1:0] bell_duration;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    // Configuration registers.
    tcb_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .bell_duration (bell_duration)
    );

    // Cell ring memory.
    tcb_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer.
    tcb_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_SIZE (TAB_SIZE),
        .AW       (AW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_in      (s_char_in),
        .s_cell_index   (s_cell_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_char    (m_cell_char),
        .m_cell_filled  (m_cell_filled),
        .m_cursor_at    (m_cursor_at),
        .m_filled_count (m_filled_count),
        .m_view_start   (m_view_start),
        .m_bell_on      (m_bell_on),
        .bell_duration  (bell_duration),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

endmodule

// ----- hdl/tcb_cell_ram.sv -----
`timescale 1ns / 1ps
// Character cell ring memory: one write port, one registered read port.
module tcb_cell_ram #(
    parameter int DEPTH = tcb_pkg::COLUMNS_DEF * tcb_pkg::ROWS_DEF,
    parameter int AW    = $clog2(tcb_pkg::COLUMNS_DEF * tcb_pkg::ROWS_DEF)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [tcb_pkg::CHAR_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [tcb_pkg::CHAR_W-1:0]  rdata
);
    import tcb_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tcb_regs.sv -----
`timescale 1ns / 1ps
// APB configuration register file holding the bell duration.
module tcb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcb_pkg::APB_AW-1:0]  paddr,
    input  logic [tcb_pkg::APB_DW-1:0]  pwdata,
    output logic [tcb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [tcb_pkg::CHAR_W-1:0]  bell_duration
);
    import tcb_pkg::*;

    logic [CHAR_W-1:0] bell_dur_reg;
    logic              wr_en;
    logic              sel_bell;

    assign pready   = 1'b1;
    assign sel_bell = (paddr[APB_AW-1] == REG_BELL);
    assign wr_en    = psel && penable && pwrite && pready;

    // Register write at the access phase of a write transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bell_dur_reg <= BELL_RESET;
        end else if (wr_en && sel_bell) begin
            bell_dur_reg <= pwdata[CHAR_W-1:0];
        end
    end

    // Read data; only the top address bit is decoded, and addresses with it set read as zero.
    always_comb begin
        prdata = '0;
        if (sel_bell) begin
            prdata = APB_DW'(bell_dur_reg);
        end
    end

    assign bell_duration = bell_dur_reg;

endmodule

// ----- hdl/tcb_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: byte decoding, cursor and ring pointers, blank fill and cell reads.
module tcb_ctrl #(
    parameter int COLUMNS  = tcb_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcb_pkg::ROWS_DEF,
    parameter int TAB_SIZE = tcb_pkg::TAB_SIZE_DEF,
    parameter int AW       = $clog2(tcb_pkg::COLUMNS_DEF * tcb_pkg::ROWS_DEF)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tcb_pkg::OP_W-1:0]    s_op,
    input  logic [tcb_pkg::CHAR_W-1:0]  s_char_in,
    input  logic [tcb_pkg::POS_W-1:0]   s_cell_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tcb_pkg::CHAR_W-1:0]  m_cell_char,
    output logic                        m_cell_filled,
    output logic [tcb_pkg::POS_W-1:0]   m_cursor_at,
    output logic [tcb_pkg::POS_W-1:0]   m_filled_count,
    output logic [tcb_pkg::POS_W-1:0]   m_view_start,
    output logic                        m_bell_on,
    input  logic [tcb_pkg::CHAR_W-1:0]  bell_duration,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [tcb_pkg::CHAR_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [tcb_pkg::CHAR_W-1:0]  mem_rdata
);
    import tcb_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    // Positions including the overshoot of a line step before scrolling.
    localparam int PW    = $clog2(2 * CELLS);
    localparam int IW    = (PW > POS_W) ? PW : POS_W;
    localparam int CW    = $clog2(COLUMNS);
    localparam int TW    = $clog2(TAB_SIZE + 1);

    localparam logic [PW-1:0] CELLS_P  = PW'(CELLS);
    localparam logic [PW-1:0] COLS_P   = PW'(COLUMNS);
    localparam logic [PW-1:0] TAB_P    = PW'(TAB_SIZE);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [TW-1:0] TPH_LAST = TW'(TAB_SIZE - 1);
    localparam logic [TW-1:0] TPH_WRAP = TW'((COLUMNS - 1) % TAB_SIZE);

    tcb_state_t state_reg, state_next;

    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [POS_W-1:0]  idx_reg;

    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] used_reg,   used_next;
    logic [PW-1:0] start_reg,  start_next;
    logic [PW-1:0] tgt_reg,    tgt_next;
    logic [CW-1:0] col_reg,    col_next;
    logic [TW-1:0] tph_reg,    tph_next;
    logic [CHAR_W-1:0] bell_reg, bell_next;
    logic hit_reg, hit_next;

    logic m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg;
    logic m_filled_reg;
    logic [POS_W-1:0] m_cursor_reg, m_used_reg, m_start_reg;
    logic m_bell_reg;
    logic out_load;

    logic [PW-1:0] col_w;
    logic [PW-1:0] inc_w;
    logic [PW-1:0] scroll_start;
    logic          adv_en;
    logic [PW-1:0] adv_step;
    logic [PW-1:0] adv_tgt;

    // Ring index of a screen position: one compare and subtract.
    function automatic logic [AW-1:0] ring(input logic [PW-1:0] base,
                                           input logic [PW-1:0] pos);
        logic [PW-1:0] sum;
        sum = base + pos;
        if (sum >= CELLS_P) begin
            sum = sum - CELLS_P;
        end
        return AW'(sum);
    endfunction

    assign col_w        = PW'(col_reg);
    assign inc_w        = TAB_P - PW'(tph_reg);
    assign scroll_start = PW'(ring(start_reg, COLS_P));

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            used_reg    <= '0;
            start_reg   <= '0;
            col_reg     <= '0;
            tph_reg     <= '0;
            bell_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            used_reg    <= used_next;
            start_reg   <= start_next;
            col_reg     <= col_next;
            tph_reg     <= tph_next;
            bell_reg    <= bell_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item capture, fill target and result payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            ch_reg  <= s_char_in;
            idx_reg <= s_cell_index;
        end
        tgt_reg <= tgt_next;
        hit_reg <= hit_next;
        if (out_load) begin
            m_char_reg   <= hit_reg ? mem_rdata : '0;
            m_filled_reg <= hit_reg;
            m_cursor_reg <= POS_W'(cursor_reg);
            m_used_reg   <= POS_W'(used_reg);
            m_start_reg  <= POS_W'(start_reg);
            m_bell_reg   <= (bell_reg != '0);
        end
    end

    // Next state, pointer updates and memory accesses.
    always_comb begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        used_next   = used_reg;
        start_next  = start_reg;
        col_next    = col_reg;
        tph_next    = tph_reg;
        tgt_next    = tgt_reg;
        bell_next   = bell_reg;
        hit_next    = hit_reg;
        mem_we      = 1'b0;
        mem_waddr   = ring(start_reg, used_reg);
        mem_wdata   = CH_SPACE;
        mem_re      = 1'b0;
        mem_raddr   = ring(start_reg, PW'(idx_reg));
        s_ready     = 1'b0;
        out_load    = 1'b0;
        adv_en      = 1'b0;
        adv_step    = COLS_P;
        adv_tgt     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_RESP;
                hit_next   = 1'b0;
                if (op_reg == OP_RECV) begin
                    unique case (ch_reg)
                        CH_NUL: begin
                        end
                        CH_BEL: begin
                            bell_next = bell_duration;
                        end
                        CH_BS: begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - PW'(1);
                                if (col_reg == '0) begin
                                    col_next = COL_LAST;
                                    tph_next = TPH_WRAP;
                                end else begin
                                    col_next = col_reg - CW'(1);
                                    tph_next = (tph_reg == '0) ? TPH_LAST : tph_reg - TW'(1);
                                end
                            end
                        end
                        CH_TAB: begin
                            if (col_w + inc_w >= COLS_P) begin
                                // The next stop lies past the row: acts as line feed.
                                adv_en   = 1'b1;
                                adv_step = COLS_P - col_w;
                                col_next = '0;
                                tph_next = '0;
                            end else begin
                                cursor_next = cursor_reg + inc_w;
                                tgt_next    = cursor_reg + inc_w;
                                col_next    = col_reg + CW'(inc_w);
                                tph_next    = '0;
                                if (cursor_reg + inc_w > used_reg) begin
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        CH_LF: begin
                            adv_en   = 1'b1;
                            adv_step = COLS_P - col_w;
                            col_next = '0;
                            tph_next = '0;
                        end
                        CH_VT: begin
                            adv_en   = 1'b1;
                            adv_step = COLS_P;
                        end
                        CH_FF: begin
                            cursor_next = '0;
                            used_next   = '0;
                            start_next  = '0;
                            col_next    = '0;
                            tph_next    = '0;
                        end
                        CH_CR: begin
                            cursor_next = cursor_reg - col_w;
                            col_next    = '0;
                            tph_next    = '0;
                        end
                        default: begin
                            // Store a character at the cursor, clamping high codes.
                            mem_we    = 1'b1;
                            mem_waddr = ring(start_reg, cursor_reg);
                            mem_wdata = ch_reg[CHAR_W-1] ? CH_HIGH : ch_reg;
                            if (cursor_reg < used_reg) begin
                                cursor_next = cursor_reg + PW'(1);
                            end else if (cursor_reg + PW'(1) >= CELLS_P) begin
                                cursor_next = cursor_reg + PW'(1) - COLS_P;
                                used_next   = used_reg + PW'(1) - COLS_P;
                                start_next  = scroll_start;
                            end else begin
                                cursor_next = cursor_reg + PW'(1);
                                used_next   = used_reg + PW'(1);
                            end
                            if (col_reg == COL_LAST) begin
                                col_next = '0;
                                tph_next = '0;
                            end else begin
                                col_next = col_reg + CW'(1);
                                tph_next = (tph_reg == TPH_LAST) ? '0 : tph_reg + TW'(1);
                            end
                        end
                    endcase
                end else if (op_reg == OP_READ) begin
                    mem_re   = 1'b1;
                    hit_next = (IW'(idx_reg) < IW'(used_reg)) &&
                               (IW'(idx_reg) < IW'(CELLS));
                end else if (op_reg == OP_TICK) begin
                    if (bell_reg != '0) begin
                        bell_next = bell_reg - CHAR_W'(1);
                    end
                end

                // Line step: scroll one row if it runs off the screen, then blank-fill.
                if (adv_en) begin
                    adv_tgt = cursor_reg + adv_step;
                    if (adv_tgt > used_reg) begin
                        if (adv_tgt >= CELLS_P) begin
                            start_next = scroll_start;
                            used_next  = used_reg - COLS_P;
                            adv_tgt    = adv_tgt - COLS_P;
                        end
                        tgt_next   = adv_tgt;
                        state_next = ST_FILL;
                    end
                    cursor_next = adv_tgt;
                end
            end

            ST_FILL: begin
                // One blank cell per cycle at the end of the filled text.
                mem_we    = 1'b1;
                used_next = used_reg + PW'(1);
                if (used_reg + PW'(1) == tgt_reg) begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_char    = m_char_reg;
    assign m_cell_filled  = m_filled_reg;
    assign m_cursor_at    = m_cursor_reg;
    assign m_filled_count = m_used_reg;
    assign m_view_start   = m_start_reg;
    assign m_bell_on      = m_bell_reg;

endmodule

// ----- tb/text_console_char_buffer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the text console character buffer: random and directed traffic.
module text_console_char_buffer_tb;
    import tcb_pkg::*;

    // Console geometry and run constants.
    localparam int COLS         = COLUMNS_DEF;
    localparam int CELLS        = COLUMNS_DEF * ROWS_DEF;
    localparam int TAB_W        = TAB_SIZE_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] BELL_ADDR = APB_AW'(4 * REG_BELL);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  idx;
    } console_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              cell_filled;
        logic [POS_W-1:0]  cursor_at;
        logic [POS_W-1:0]  filled_count;
        logic [POS_W-1:0]  view_start;
        logic              bell_on;
    } console_view_t;

    // Clock, reset and block ports.
    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op           = OP_RECV;
    logic [CHAR_W-1:0]   s_char_in      = CH_NUL;
    logic [POS_W-1:0]    s_cell_index   = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [CHAR_W-1:0]   m_cell_char;
    logic                m_cell_filled;
    logic [POS_W-1:0]    m_cursor_at;
    logic [POS_W-1:0]    m_filled_count;
    logic [POS_W-1:0]    m_view_start;
    logic                m_bell_on;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Pending byte/read/tick transactions and the screen views they should produce.
    console_item_t console_items[$];
    console_view_t expected_views[$];

    // Shadow copy of the console state.
    logic [CHAR_W-1:0] shadow_cells [0:CELLS-1];
    int cur_pos     = 0;
    int top_ring    = 0;
    int used_cells  = 0;
    int bell_left   = 0;
    int bell_len    = BELL_RESET;

    // Run bookkeeping.
    int error_count   = 0;
    int checked_count = 0;
    int scroll_count  = 0;
    int cycle_count   = 0;
    int op_seen [4]   = '{0, 0, 0, 0};
    int hold_asks     = 0;
    int holds_taken   = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    int tx_wait       = 0;
    int rx_wait       = 0;
    int hold_left     = 0;
    logic [CHAR_W-1:0] last_bell = BELL_RESET;

    text_console_char_buffer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_in      (s_char_in),
        .s_cell_index   (s_cell_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_char    (m_cell_char),
        .m_cell_filled  (m_cell_filled),
        .m_cursor_at    (m_cursor_at),
        .m_filled_count (m_filled_count),
        .m_view_start   (m_view_start),
        .m_bell_on      (m_bell_on),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // Shift the view down by one row.
    task automatic scroll_one_row();
        cur_pos    -= COLS;
        top_ring    = (top_ring + COLS) % CELLS;
        used_cells -= COLS;
        scroll_count++;
    endtask

    // Move the cursor down by step cells, blank-filling new cells and scrolling at the end.
    task automatic step_down(input int step);
        int gap;
        if (cur_pos + step > used_cells) begin
            if (cur_pos + step >= CELLS) begin
                scroll_one_row();
            end
            gap = cur_pos + step - used_cells;
            for (int k = 0; k < gap; k++) begin
                shadow_cells[(top_ring + used_cells + k) % CELLS] = CH_SPACE;
            end
            used_cells += gap;
        end
        cur_pos += step;
    endtask

    // Handle one received byte: control codes or a stored character.
    task automatic receive_byte(input logic [CHAR_W-1:0] ch);
        int col;
        int inc;
        logic [CHAR_W-1:0] code;
        code = ch;
        case (ch)
            CH_NUL: begin
            end
            CH_BEL: begin
                bell_left = bell_len;
            end
            CH_BS: begin
                if (cur_pos > 0) cur_pos--;
            end
            CH_TAB: begin
                col = cur_pos % COLS;
                inc = TAB_W - (col % TAB_W);
                if (col + inc >= COLS) begin
                    step_down(COLS - col);
                end else begin
                    for (int k = 0; k < inc; k++) begin
                        if (cur_pos >= used_cells) begin
                            shadow_cells[(top_ring + cur_pos) % CELLS] = CH_SPACE;
                            used_cells++;
                        end
                        cur_pos++;
                    end
                end
            end
            CH_LF: begin
                step_down(COLS - cur_pos % COLS);
            end
            CH_VT: begin
                step_down(COLS);
            end
            CH_FF: begin
                cur_pos    = 0;
                used_cells = 0;
                top_ring   = 0;
            end
            CH_CR: begin
                cur_pos -= cur_pos % COLS;
            end
            default: begin
                if (code >= CH_HIGH) code = CH_HIGH;
                shadow_cells[(top_ring + cur_pos) % CELLS] = code;
                if (cur_pos < used_cells) begin
                    cur_pos++;
                end else begin
                    used_cells++;
                    cur_pos++;
                    if (cur_pos >= CELLS) scroll_one_row();
                end
            end
        endcase
    endtask

    // Apply one transaction to the shadow state and work out the view it returns.
    task automatic console_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [POS_W-1:0] idx, output console_view_t view);
        int pos;
        view = '0;
        pos  = idx;
        case (op)
            OP_RECV: begin
                receive_byte(ch);
            end
            OP_READ: begin
                if (pos < used_cells && pos < CELLS) begin
                    view.cell_filled = 1'b1;
                    view.cell_char   = shadow_cells[(top_ring + pos) % CELLS];
                end
            end
            OP_TICK: begin
                if (bell_left > 0) bell_left--;
            end
            default: begin
            end
        endcase
        view.cursor_at    = POS_W'(cur_pos);
        view.filled_count = POS_W'(used_cells);
        view.view_start   = POS_W'(top_ring);
        view.bell_on      = (bell_left != 0);
    endtask

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [POS_W-1:0] idx);
        console_items.push_back('{op: op, ch: ch, idx: idx});
    endtask

    // Mostly text with line control mixed in, so the screen fills and scrolls; rare clears.
    task automatic queue_random(input int count);
        int r;
        int k;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  idx;
        for (int n = 0; n < count; n++) begin
            r   = $urandom_range(0, 99);
            ch  = CHAR_W'($urandom_range(0, 255));
            idx = POS_W'($urandom_range(0, 255));
            if (r < 64) begin
                op = OP_RECV;
                k  = $urandom_range(0, 199);
                if (k < 120) begin
                    ch = CHAR_W'($urandom_range(32, 126));
                end else if (k < 140) begin
                    ch = CHAR_W'($urandom_range(128, 255));
                end else if (k < 150) begin
                    ch = CHAR_W'($urandom_range(0, 31));
                end else if (k < 199) begin
                    case ($urandom_range(0, 6))
                        0:       ch = CH_NUL;
                        1:       ch = CH_BEL;
                        2:       ch = CH_BS;
                        3:       ch = CH_TAB;
                        4:       ch = CH_LF;
                        5:       ch = CH_VT;
                        default: ch = CH_CR;
                    endcase
                end else begin
                    ch = CH_FF;
                end
            end else if (r < 84) begin
                op = OP_READ;
                if ($urandom_range(0, 9) < 7) idx = POS_W'($urandom_range(0, CELLS - 1));
            end else if (r < 97) begin
                op = OP_TICK;
            end else begin
                op = OP_UNUSED;
            end
            queue_item(op, ch, idx);
        end
    endtask

    // The sender stops until every expected view has come back, then lets the block settle.
    task automatic wait_console_idle(input int settle);
        while (console_items.size() != 0 || s_valid || expected_views.size() != 0) begin
            @(negedge aclk);
        end
        repeat (settle) @(negedge aclk);
    endtask

    // Write the bell length over APB, then read it back.
    task automatic bell_setting(input logic [CHAR_W-1:0] val);
        logic [APB_DW-1:0] readback;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BELL_ADDR;
        pwdata  <= APB_DW'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        bell_len  = val;
        last_bell = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        if (readback !== APB_DW'(val)) begin
            error_count++;
            if (error_count <= 10) begin
                $display("bell_duration readback: expected %0d, got %0d", val, readback);
            end
        end
    endtask

    // Sender: presents queued transactions and predicts each one as it is accepted.
    always @(posedge aclk) begin
        console_view_t want;
        console_item_t next;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait  = 0;
        end else begin
            if (s_valid && s_ready) begin
                console_step(s_op, s_char_in, s_cell_index, want);
                expected_views.push_back(want);
                op_seen[s_op]++;
            end
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (console_items.size() != 0) begin
                    next          = console_items.pop_front();
                    s_valid      <= 1'b1;
                    s_op         <= next.op;
                    s_char_in    <= next.ch;
                    s_cell_index <= next.idx;
                    tx_wait       = tx_calm ? 0 : $urandom_range(0, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        console_view_t got;
        console_view_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_cell_char, m_cell_filled, m_cursor_at, m_filled_count,
                       m_view_start, m_bell_on};
                if (expected_views.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Unexpected result: char %0d filled %0d cursor %0d used %0d",
                                 got.cell_char, got.cell_filled, got.cursor_at,
                                 got.filled_count);
                    end
                end else begin
                    want = expected_views.pop_front();
                    checked_count++;
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("Mismatch at result %0d:", checked_count);
                            $display("  expected char %0d filled %0d cursor %0d used %0d view %0d bell %0d",
                                     want.cell_char, want.cell_filled, want.cursor_at,
                                     want.filled_count, want.view_start, want.bell_on);
                            $display("  actual   char %0d filled %0d cursor %0d used %0d view %0d bell %0d",
                                     got.cell_char, got.cell_filled, got.cursor_at,
                                     got.filled_count, got.view_start, got.bell_on);
                        end
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (holds_taken != hold_asks) begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_char_buffer test failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        for (int k = 0; k < CELLS; k++) shadow_cells[k] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty reads, clamping, every control code, tab stops up to the row end.
        queue_item(OP_READ, CH_NUL, 8'd0);
        queue_item(OP_READ, 8'hFF, 8'd255);
        queue_item(OP_RECV, 8'h41, 8'd0);
        queue_item(OP_RECV, 8'hFF, 8'd0);
        queue_item(OP_RECV, CH_HIGH, 8'd0);
        queue_item(OP_RECV, 8'h7F, 8'd0);
        queue_item(OP_RECV, 8'h01, 8'd0);
        queue_item(OP_RECV, CH_TAB, 8'd0);
        queue_item(OP_RECV, CH_BS, 8'd0);
        queue_item(OP_RECV, CH_CR, 8'd0);
        queue_item(OP_READ, CH_NUL, 8'd1);
        queue_item(OP_RECV, CH_BEL, 8'd0);
        queue_item(OP_TICK, CH_NUL, 8'd0);
        queue_item(OP_UNUSED, 8'hFF, 8'hFF);
        queue_item(OP_RECV, CH_NUL, 8'd0);
        queue_item(OP_RECV, CH_LF, 8'd0);
        queue_item(OP_RECV, CH_VT, 8'd0);
        queue_item(OP_READ, CH_NUL, 8'd30);
        queue_item(OP_RECV, CH_FF, 8'd0);
        for (int k = 0; k < 6; k++) queue_item(OP_RECV, CH_TAB, 8'd0);
        wait_console_idle(0);

        // Random traffic at the reset bell length, starting with a long receiver stall.
        queue_random(450);
        hold_asks++;
        wait_console_idle(SETTLE);

        // Longest bell, no idling on either side.
        bell_setting(8'd255);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        queue_random(300);
        wait_console_idle(SETTLE);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Zero bell length: BEL leaves the bell off, and ticks with the bell off.
        bell_setting(8'd0);
        queue_item(OP_RECV, CH_BEL, 8'd0);
        queue_item(OP_TICK, CH_NUL, 8'd0);
        queue_item(OP_READ, CH_NUL, 8'd0);
        queue_random(200);
        wait_console_idle(SETTLE);

        // Shortest nonzero bell.
        bell_setting(8'd1);
        queue_random(300);
        wait_console_idle(SETTLE);

        // A random bell length with another long stall on the receiver.
        bell_setting(CHAR_W'($urandom_range(2, 254)));
        queue_random(120);
        hold_asks++;
        wait_console_idle(40);

        error_count += expected_views.size();
        $display("Checked %0d results: %0d bytes, %0d reads, %0d ticks, %0d unused-op items.",
                 checked_count, op_seen[OP_RECV], op_seen[OP_READ], op_seen[OP_TICK],
                 op_seen[OP_UNUSED]);
        $display("Screen scrolled %0d rows; bell lengths 20, 255, 0, 1 and %0d were used.",
                 scroll_count, last_bell);
        if (error_count == 0) begin
            $display("text_console_char_buffer test passed");
        end else begin
            $display("text_console_char_buffer test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tcb_pkg.sv
hdl/tcb_cell_ram.sv
hdl/tcb_regs.sv
hdl/tcb_ctrl.sv
hdl/text_console_char_buffer.sv
tb/text_console_char_buffer_tb.sv
